// ===== rtl/rbnh_pkg.sv =====
package rbnh_pkg;

    // table depth and derived widths
    localparam int MAX_BOXES = 128;
    localparam int BOX_AW    = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CNT_RAW_W = $clog2(MAX_BOXES + 1);
    localparam int N_W       = (CNT_RAW_W > 8) ? CNT_RAW_W : 8;

    // result codes
    localparam logic [2:0]  FACE_NONE  = 3'd6;
    localparam logic [30:0] NOHIT_DIST = 31'h7FFF_FFFF;

    // command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_CAST  = 1'b1;

    // one table entry
    typedef struct packed {
        logic signed [31:0] size_z;
        logic signed [31:0] size_y;
        logic signed [31:0] size_x;
        logic signed [31:0] corner_z;
        logic signed [31:0] corner_y;
        logic signed [31:0] corner_x;
    } box_t;

endpackage

// ===== rtl/ray_box_nearest_hit.sv =====
// ray_box_nearest_hit: nearest-hit ray cast against a table of boxes
//
// input channel (in_valid/in_ready): cmd 0 stores a box (corner in pos_*,
// sizes in vec_*) into slot; cmd 1 casts a ray (origin pos_*, direction vec_*)
// and yields one beat on the output channel (out_valid/out_ready).
// box_count is written through cfg_we/cfg_wdata; the user must do so only while
// the block is idle, as the block itself does not enforce it.
// a box write goes into the table as it is accepted. a ray cast runs one
// item at a time: squares of the direction components, square root,
// direction normalization, then for each of min(box_count, MAX_BOXES) boxes
// a table read and per face the plane distance (31-step shared radix-2
// divider), the hit point via the shared multiplier and a setup/compare;
// a skipped face omits the division and the hit point. the table is one
// synchronous memory read once per box.
//
// the result sits in an output register; a new beat is accepted while it
// waits. if a second cast finishes before the first result is taken, the
// block holds the second result until out_ready frees the register.
// reset clears box_count and all control state; table contents are
// undefined until written.
module ray_box_nearest_hit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [7:0]         cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               cmd,
    input  logic [6:0]         slot,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [31:0] vec_x,
    input  logic signed [31:0] vec_y,
    input  logic signed [31:0] vec_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               hit,
    output logic signed [31:0] hit_x,
    output logic signed [31:0] hit_y,
    output logic signed [31:0] hit_z,
    output logic [2:0]         face,
    output logic [30:0]        distance
);

    localparam int N_W = rbnh_pkg::N_W;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SQMUL  = 4'd1;
    localparam logic [3:0] S_SQACC  = 4'd2;
    localparam logic [3:0] S_SQRT   = 4'd3;
    localparam logic [3:0] S_NLOAD  = 4'd4;
    localparam logic [3:0] S_NDIV   = 4'd5;
    localparam logic [3:0] S_BOXRD  = 4'd6;
    localparam logic [3:0] S_BOXLAT = 4'd7;
    localparam logic [3:0] S_PLANE  = 4'd8;
    localparam logic [3:0] S_PCHK   = 4'd9;
    localparam logic [3:0] S_KDIV   = 4'd10;
    localparam logic [3:0] S_HMUL   = 4'd11;
    localparam logic [3:0] S_HACC   = 4'd12;
    localparam logic [3:0] S_CMP    = 4'd13;
    localparam logic [3:0] S_NEXT   = 4'd14;
    localparam logic [3:0] S_FINISH = 4'd15;

    logic [3:0] state_reg;
    logic [7:0] box_count_reg;

    // cast operands
    logic signed [31:0] p_reg [3];
    logic [31:0]        dmag_reg [3];
    logic [2:0]         dneg_reg;
    logic signed [17:0] u_reg [3];
    logic signed [31:0] c_reg [3];
    logic signed [33:0] up_reg [3];

    logic [1:0]     a_reg;
    logic [2:0]     i_reg;
    logic [1:0]     e_reg;
    logic [N_W-1:0] b_reg;
    logic [N_W-1:0] n_reg;

    logic [63:0] sumsq_reg;
    logic [63:0] sq_x_reg;
    logic [35:0] sq_rem_reg;
    logic [31:0] root_reg;
    logic [4:0]  sq_cnt_reg;

    logic signed [65:0] prod_reg;

    // shared divider
    logic [34:0] div_rem_reg;
    logic [33:0] div_dvs_reg;
    logic [49:0] div_lo_reg;
    logic [30:0] div_q_reg;
    logic [4:0]  div_cnt_reg;

    logic signed [34:0] plane_reg;
    logic signed [34:0] num_reg;
    logic [30:0]        k_reg;
    logic               inside_reg;
    logic signed [31:0] hp_reg [3];

    logic               found_reg;
    logic [30:0]        best_k_reg;
    logic [2:0]         best_face_reg;
    logic signed [31:0] best_pt_reg [3];

    logic               out_valid_reg;
    logic               hit_reg;
    logic signed [31:0] hit_x_reg;
    logic signed [31:0] hit_y_reg;
    logic signed [31:0] hit_z_reg;
    logic [2:0]         face_reg;
    logic [30:0]        distance_reg;

    // box table
    localparam int BOX_W = $bits(rbnh_pkg::box_t);
    logic [BOX_W-1:0]  mem [rbnh_pkg::MAX_BOXES];
    rbnh_pkg::box_t    rd_data_reg;
    logic              wr_en;
    logic              rd_en;

    logic accept;
    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign wr_en    = accept && (cmd == rbnh_pkg::CMD_WRITE)
                      && ({25'd0, slot} < rbnh_pkg::MAX_BOXES);
    assign rd_en    = (state_reg == S_BOXRD) && (b_reg < n_reg);

    // table write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[slot[rbnh_pkg::BOX_AW-1:0]] <= {vec_z, vec_y, vec_x, pos_z, pos_y, pos_x};
        end
        if (rd_en)
        begin
            rd_data_reg <= rbnh_pkg::box_t'(mem[b_reg[rbnh_pkg::BOX_AW-1:0]]);
        end
    end

    // axis of the current face
    logic [1:0] pa;
    assign pa = (i_reg >= 3'd3) ? 2'(i_reg - 3'd3) : i_reg[1:0];

    // input magnitudes
    logic [32:0] vmag [3];
    always_comb
    begin
        vmag[0] = vec_x[31] ? -{vec_x[31], vec_x} : {1'b0, vec_x};
        vmag[1] = vec_y[31] ? -{vec_y[31], vec_y} : {1'b0, vec_y};
        vmag[2] = vec_z[31] ? -{vec_z[31], vec_z} : {1'b0, vec_z};
    end

    // shared multiplier operands
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    always_comb
    begin
        if (state_reg == S_SQMUL)
        begin
            mul_a = $signed({1'b0, dmag_reg[a_reg]});
            mul_b = $signed({1'b0, dmag_reg[a_reg]});
        end
        else
        begin
            mul_a = 33'(u_reg[e_reg]);
            mul_b = $signed({2'b0, k_reg});
        end
    end

    // square root step, two bits a cycle
    logic [35:0] sq_t;
    logic [35:0] sq_trial;
    logic        sq_ge;
    assign sq_t     = {sq_rem_reg[33:0], sq_x_reg[63:62]};
    assign sq_trial = {2'b0, root_reg, 2'b01};
    assign sq_ge    = sq_t >= sq_trial;

    // divider step
    logic [34:0] div_t;
    logic        div_ge;
    assign div_t  = {div_rem_reg[33:0], div_lo_reg[49]};
    assign div_ge = div_t >= {1'b0, div_dvs_reg};

    // plane checks
    logic [33:0] num_mag;
    logic [16:0] u_mag;
    logic        pskip;
    always_comb
    begin
        num_mag = num_reg[34] ? 34'(-num_reg) : num_reg[33:0];
        u_mag   = u_reg[pa][17] ? 17'(-u_reg[pa]) : u_reg[pa][16:0];
        pskip   = (u_reg[pa] == 18'sd0)
                  || ((num_reg != 35'sd0) && (num_reg[34] != u_reg[pa][17]))
                  || ({15'd0, num_mag[33:15]} >= {17'd0, u_mag});
    end

    // hit coordinate on one axis
    logic signed [34:0] hp_val;
    logic               hp_in;
    always_comb
    begin
        if (e_reg == pa)
        begin
            hp_val = plane_reg;
        end
        else
        begin
            hp_val = 35'(p_reg[e_reg]) + 35'(prod_reg >>> 16);
        end
        hp_in = (hp_val >= 35'(c_reg[e_reg])) && (hp_val <= 35'(up_reg[e_reg]));
    end

    // box count clamp
    logic [N_W-1:0] n_clamp;
    assign n_clamp = (N_W'(box_count_reg) > N_W'(rbnh_pkg::MAX_BOXES))
                     ? N_W'(rbnh_pkg::MAX_BOXES) : N_W'(box_count_reg);

    // config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_count_reg <= 8'd0;
        end
        else if (cfg_we)
        begin
            box_count_reg <= cfg_wdata;
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            a_reg         <= 2'd0;
            i_reg         <= 3'd0;
            e_reg         <= 2'd0;
            b_reg         <= '0;
            sq_cnt_reg    <= 5'd0;
            div_cnt_reg   <= 5'd0;
        end
        else
        begin
            if (out_valid_reg && out_ready && (state_reg != S_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept && (cmd == rbnh_pkg::CMD_CAST))
                    begin
                        found_reg <= 1'b0;
                        a_reg     <= 2'd0;
                        state_reg <= S_SQMUL;
                    end
                end
                S_SQMUL:
                begin
                    state_reg <= S_SQACC;
                end
                S_SQACC:
                begin
                    if (a_reg == 2'd2)
                    begin
                        a_reg      <= 2'd0;
                        sq_cnt_reg <= 5'd31;
                        state_reg  <= S_SQRT;
                    end
                    else
                    begin
                        a_reg     <= a_reg + 2'd1;
                        state_reg <= S_SQMUL;
                    end
                end
                S_SQRT:
                begin
                    sq_cnt_reg <= sq_cnt_reg - 5'd1;
                    if (sq_cnt_reg == 5'd0)
                    begin
                        if ({root_reg[30:0], sq_ge} == 32'd0)
                        begin
                            state_reg <= S_FINISH;
                        end
                        else
                        begin
                            state_reg <= S_NLOAD;
                        end
                    end
                end
                S_NLOAD:
                begin
                    div_cnt_reg <= 5'd17;
                    state_reg   <= S_NDIV;
                end
                S_NDIV:
                begin
                    div_cnt_reg <= div_cnt_reg - 5'd1;
                    if (div_cnt_reg == 5'd1)
                    begin
                        if (a_reg == 2'd2)
                        begin
                            b_reg     <= '0;
                            state_reg <= S_BOXRD;
                        end
                        else
                        begin
                            a_reg     <= a_reg + 2'd1;
                            state_reg <= S_NLOAD;
                        end
                    end
                end
                S_BOXRD:
                begin
                    if (rd_en)
                    begin
                        state_reg <= S_BOXLAT;
                    end
                    else
                    begin
                        state_reg <= S_FINISH;
                    end
                end
                S_BOXLAT:
                begin
                    i_reg     <= 3'd0;
                    state_reg <= S_PLANE;
                end
                S_PLANE:
                begin
                    state_reg <= S_PCHK;
                end
                S_PCHK:
                begin
                    if (pskip)
                    begin
                        state_reg <= S_NEXT;
                    end
                    else
                    begin
                        div_cnt_reg <= 5'd31;
                        state_reg   <= S_KDIV;
                    end
                end
                S_KDIV:
                begin
                    div_cnt_reg <= div_cnt_reg - 5'd1;
                    if (div_cnt_reg == 5'd1)
                    begin
                        e_reg     <= 2'd0;
                        state_reg <= S_HMUL;
                    end
                end
                S_HMUL:
                begin
                    state_reg <= S_HACC;
                end
                S_HACC:
                begin
                    if (e_reg == 2'd2)
                    begin
                        state_reg <= S_CMP;
                    end
                    else
                    begin
                        e_reg     <= e_reg + 2'd1;
                        state_reg <= S_HMUL;
                    end
                end
                S_CMP:
                begin
                    if (inside_reg && (!found_reg || (k_reg < best_k_reg)))
                    begin
                        found_reg <= 1'b1;
                    end
                    state_reg <= S_NEXT;
                end
                S_NEXT:
                begin
                    if (i_reg == 3'd5)
                    begin
                        b_reg     <= b_reg + 1'b1;
                        state_reg <= S_BOXRD;
                    end
                    else
                    begin
                        i_reg     <= i_reg + 3'd1;
                        state_reg <= S_PLANE;
                    end
                end
                S_FINISH:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (cmd == rbnh_pkg::CMD_CAST))
                begin
                    p_reg[0]       <= pos_x;
                    p_reg[1]       <= pos_y;
                    p_reg[2]       <= pos_z;
                    dmag_reg[0]    <= vmag[0][31:0];
                    dmag_reg[1]    <= vmag[1][31:0];
                    dmag_reg[2]    <= vmag[2][31:0];
                    dneg_reg       <= {vec_z[31], vec_y[31], vec_x[31]};
                    sumsq_reg      <= 64'd0;
                    n_reg          <= n_clamp;
                    best_k_reg     <= rbnh_pkg::NOHIT_DIST;
                    best_face_reg  <= rbnh_pkg::FACE_NONE;
                    best_pt_reg[0] <= 32'sd0;
                    best_pt_reg[1] <= 32'sd0;
                    best_pt_reg[2] <= 32'sd0;
                end
            end
            S_SQMUL:
            begin
                prod_reg <= mul_a * mul_b;
            end
            S_SQACC:
            begin
                if (a_reg == 2'd2)
                begin
                    sq_x_reg   <= sumsq_reg + 64'(prod_reg);
                    sq_rem_reg <= 36'd0;
                    root_reg   <= 32'd0;
                end
                else
                begin
                    sumsq_reg <= sumsq_reg + 64'(prod_reg);
                end
            end
            S_SQRT:
            begin
                sq_x_reg   <= {sq_x_reg[61:0], 2'b00};
                sq_rem_reg <= sq_ge ? (sq_t - sq_trial) : sq_t;
                root_reg   <= {root_reg[30:0], sq_ge};
            end
            S_NLOAD:
            begin
                div_rem_reg <= {4'd0, dmag_reg[a_reg][31:1]};
                div_lo_reg  <= {dmag_reg[a_reg][0], 49'd0};
                div_dvs_reg <= {2'b0, root_reg};
                div_q_reg   <= 31'd0;
            end
            S_NDIV, S_KDIV:
            begin
                div_rem_reg <= div_ge ? (div_t - {1'b0, div_dvs_reg}) : div_t;
                div_lo_reg  <= {div_lo_reg[48:0], 1'b0};
                div_q_reg   <= {div_q_reg[29:0], div_ge};
                if ((state_reg == S_NDIV) && (div_cnt_reg == 5'd1))
                begin
                    u_reg[a_reg] <= dneg_reg[a_reg] ? -$signed({1'b0, div_q_reg[15:0], div_ge})
                                                    : $signed({1'b0, div_q_reg[15:0], div_ge});
                end
                if ((state_reg == S_KDIV) && (div_cnt_reg == 5'd1))
                begin
                    k_reg      <= {div_q_reg[29:0], div_ge};
                    inside_reg <= 1'b1;
                end
            end
            S_BOXLAT:
            begin
                c_reg[0]  <= rd_data_reg.corner_x;
                c_reg[1]  <= rd_data_reg.corner_y;
                c_reg[2]  <= rd_data_reg.corner_z;
                up_reg[0] <= 34'(rd_data_reg.corner_x) + 34'(rd_data_reg.size_x);
                up_reg[1] <= 34'(rd_data_reg.corner_y) + 34'(rd_data_reg.size_y);
                up_reg[2] <= 34'(rd_data_reg.corner_z) + 34'(rd_data_reg.size_z);
            end
            S_PLANE:
            begin
                if (i_reg >= 3'd3)
                begin
                    plane_reg <= 35'(up_reg[pa]);
                    num_reg   <= 35'(up_reg[pa]) - 35'(p_reg[pa]);
                end
                else
                begin
                    plane_reg <= 35'(c_reg[pa]);
                    num_reg   <= 35'(c_reg[pa]) - 35'(p_reg[pa]);
                end
            end
            S_PCHK:
            begin
                div_rem_reg <= {16'd0, num_mag[33:15]};
                div_lo_reg  <= {num_mag[14:0], 35'd0};
                div_dvs_reg <= {17'd0, u_mag};
                div_q_reg   <= 31'd0;
            end
            S_HMUL:
            begin
                prod_reg <= mul_a * mul_b;
            end
            S_HACC:
            begin
                hp_reg[e_reg] <= hp_val[31:0];
                inside_reg    <= inside_reg && hp_in;
            end
            S_CMP:
            begin
                if (inside_reg && (!found_reg || (k_reg < best_k_reg)))
                begin
                    best_k_reg     <= k_reg;
                    best_face_reg  <= i_reg;
                    best_pt_reg[0] <= hp_reg[0];
                    best_pt_reg[1] <= hp_reg[1];
                    best_pt_reg[2] <= hp_reg[2];
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    hit_reg      <= found_reg;
                    hit_x_reg    <= best_pt_reg[0];
                    hit_y_reg    <= best_pt_reg[1];
                    hit_z_reg    <= best_pt_reg[2];
                    face_reg     <= best_face_reg;
                    distance_reg <= best_k_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign hit_x     = hit_x_reg;
    assign hit_y     = hit_y_reg;
    assign hit_z     = hit_z_reg;
    assign face      = face_reg;
    assign distance  = distance_reg;

    // table read always followed by the latch cycle
    a_rd_latch: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |=> state_reg == S_BOXLAT)
        else $error("table read not followed by latch");

    // finished result held while the output register is busy
    a_finish_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH) && out_valid_reg && !out_ready |=> state_reg == S_FINISH)
        else $error("result dropped while output busy");

    // divider runs only with a live count
    a_div_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_NDIV) || (state_reg == S_KDIV) |-> div_cnt_reg != 5'd0)
        else $error("divider running with zero count");

    // a found hit carries a real face
    a_found_face: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_NEXT) && found_reg |-> best_face_reg != rbnh_pkg::FACE_NONE)
        else $error("hit without face");

    // no-hit result carries the all-ones distance
    a_nohit_dist: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) && !hit_reg |-> distance_reg == rbnh_pkg::NOHIT_DIST)
        else $error("no-hit distance wrong");

endmodule
